>>> sv/look_at_view_matrix_macros.svh
// Assertion macros shared by the look-at view matrix RTL.
`ifndef LOOK_AT_VIEW_MATRIX_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define LVM_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define LVM_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/lvm_pkg.sv
// Shared constants and types for the look-at view matrix pipeline.
package lvm_pkg;

   localparam int WORD_W     = 32;   // input and translation word
   localparam int UNIT_OUT_W = 18;   // unit vector output field
   localparam int MANT_W     = 31;   // normalized magnitude width
   localparam int ROOT_STEPS = 32;   // one result bit per square-root stage
   localparam int ACC_W      = 64;   // sum of squares / root working width
   localparam int REQ_DATA_W = 288;
   localparam int RSP_DATA_W = 264;

   // Per-vector bookkeeping carried alongside the root and divide stages.
   typedef struct packed {
      logic                   zero;
      logic [2:0]             neg;
      logic [2:0][MANT_W-1:0] mant;
   } norm_tag_type;

endpackage

>>> sv/lvm_norm3.sv
// Pipelined 3-vector normalizer: scale, square root, per-lane restoring divide.
module lvm_norm3 #(
   parameter int IN_W          = 33,
   parameter int FRACTION_BITS = 16
) (
   input  logic                            clock,
   input  logic                            ce,
   input  logic signed [IN_W-1:0]          vec_in  [3],
   output logic signed [FRACTION_BITS+1:0] vec_out [3]
);
   import lvm_pkg::*;

   localparam int FB   = FRACTION_BITS;
   localparam int QW   = FB + 1;             // quotient never exceeds 1.0
   localparam int NW   = MANT_W + 1 + FB;    // dividend width
   localparam int UW   = FB + 2;
   localparam int BL_W = $clog2(IN_W + 1);
   localparam int LW   = ROOT_STEPS;         // root / divisor width

   // stage 1: magnitudes
   logic [IN_W-1:0] mag1_ff [3], mag1_in [3];
   logic [2:0]      neg1_ff, neg1_in;
   // stage 2: largest magnitude
   logic [IN_W-1:0] mag2_ff [3];
   logic [2:0]      neg2_ff;
   logic [IN_W-1:0] mx2_ff, mx2_in;
   // stage 3: bit length of largest
   logic [IN_W-1:0] mag3_ff [3];
   logic [2:0]      neg3_ff;
   logic [BL_W-1:0] bl3_ff, bl3_in;
   logic            zero3_ff, zero3_in;
   // stage 4: scaled mantissas
   norm_tag_type    tag4_ff, tag4_in;
   // stage 5: squares
   logic [2*MANT_W-1:0] sq5_ff [3], sq5_in [3];
   norm_tag_type        tag5_ff;
   // root stages, index 0 holds the sum of squares
   logic [ACC_W-1:0] rem_ff [ROOT_STEPS+1], rem_in [ROOT_STEPS+1];
   logic [ACC_W-1:0] res_ff [ROOT_STEPS+1], res_in [ROOT_STEPS+1];
   norm_tag_type     tagr_ff [ROOT_STEPS+1];
   // divide stages, index 0 is the setup stage
   logic [LW-1:0]    rdiv_ff [QW+1][3], rdiv_in [QW+1][3];
   logic [QW-1:0]    lo_ff   [QW+1][3], lo_in   [QW+1][3];
   logic [QW-1:0]    q_ff    [QW+1][3], q_in    [QW+1][3];
   logic [LW-1:0]    lend_ff [QW+1];
   norm_tag_type     tagd_ff [QW+1];
   // result
   logic signed [UW-1:0] out_ff [3], out_in [3];

   always_comb begin
      logic [NW-1:0]   num;
      logic [LW:0]     r2;
      logic [ACC_W-1:0] bitv, trial;
      for (int i = 0; i < 3; i++) begin
         neg1_in[i] = vec_in[i][IN_W-1];
         mag1_in[i] = vec_in[i][IN_W-1] ? (~unsigned'(vec_in[i])) + IN_W'(1)
                                        : unsigned'(vec_in[i]);
      end

      mx2_in = mag1_ff[0];
      if (mag1_ff[1] > mx2_in) mx2_in = mag1_ff[1];
      if (mag1_ff[2] > mx2_in) mx2_in = mag1_ff[2];

      bl3_in = '0;
      for (int b = 0; b < IN_W; b++) begin
         if (mx2_ff[b]) bl3_in = BL_W'(b + 1);
      end
      zero3_in = (mx2_ff == '0);

      // bring the largest magnitude into [2^30, 2^31), truncating on the way down
      tag4_in.zero = zero3_ff;
      tag4_in.neg  = neg3_ff;
      for (int i = 0; i < 3; i++) begin
         if (bl3_ff > BL_W'(MANT_W)) begin
            tag4_in.mant[i] = MANT_W'(mag3_ff[i] >> (bl3_ff - BL_W'(MANT_W)));
         end else begin
            tag4_in.mant[i] = mag3_ff[i][MANT_W-1:0] << (BL_W'(MANT_W) - bl3_ff);
         end
      end

      for (int i = 0; i < 3; i++) begin
         sq5_in[i] = (2*MANT_W)'(tag4_ff.mant[i]) * (2*MANT_W)'(tag4_ff.mant[i]);
      end

      rem_in[0] = ACC_W'(sq5_ff[0]) + ACC_W'(sq5_ff[1]) + ACC_W'(sq5_ff[2]);
      res_in[0] = '0;
      // digit-by-digit integer square root, one result bit per stage
      for (int k = 0; k < ROOT_STEPS; k++) begin
         bitv  = ACC_W'(1) << (2 * (ROOT_STEPS - 1 - k));
         trial = res_ff[k] + bitv;
         if (rem_ff[k] >= trial) begin
            rem_in[k+1] = rem_ff[k] - trial;
            res_in[k+1] = (res_ff[k] >> 1) + bitv;
         end else begin
            rem_in[k+1] = rem_ff[k];
            res_in[k+1] = res_ff[k] >> 1;
         end
      end

      // dividend (m << FB) + len/2; high part is already below len
      for (int i = 0; i < 3; i++) begin
         num = (NW'(tagr_ff[ROOT_STEPS].mant[i]) << FB)
             + NW'(res_ff[ROOT_STEPS][LW-1:0] >> 1);
         rdiv_in[0][i] = LW'(num >> QW);
         lo_in[0][i]   = num[QW-1:0];
         q_in[0][i]    = '0;
      end
      for (int j = 1; j <= QW; j++) begin
         for (int i = 0; i < 3; i++) begin
            r2 = {rdiv_ff[j-1][i], lo_ff[j-1][i][QW-1]};
            lo_in[j][i] = lo_ff[j-1][i] << 1;
            if (r2 >= {1'b0, lend_ff[j-1]}) begin
               rdiv_in[j][i] = LW'(r2 - {1'b0, lend_ff[j-1]});
               q_in[j][i]    = {q_ff[j-1][i][QW-2:0], 1'b1};
            end else begin
               rdiv_in[j][i] = r2[LW-1:0];
               q_in[j][i]    = {q_ff[j-1][i][QW-2:0], 1'b0};
            end
         end
      end

      for (int i = 0; i < 3; i++) begin
         if (tagd_ff[QW].zero) begin
            out_in[i] = '0;
         end else if (tagd_ff[QW].neg[i]) begin
            out_in[i] = -signed'(UW'(q_ff[QW][i]));
         end else begin
            out_in[i] = signed'(UW'(q_ff[QW][i]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         mag1_ff  <= mag1_in;
         neg1_ff  <= neg1_in;
         mag2_ff  <= mag1_ff;
         neg2_ff  <= neg1_ff;
         mx2_ff   <= mx2_in;
         mag3_ff  <= mag2_ff;
         neg3_ff  <= neg2_ff;
         bl3_ff   <= bl3_in;
         zero3_ff <= zero3_in;
         tag4_ff  <= tag4_in;
         sq5_ff   <= sq5_in;
         tag5_ff  <= tag4_ff;
         rem_ff   <= rem_in;
         res_ff   <= res_in;
         tagr_ff[0] <= tag5_ff;
         for (int k = 1; k <= ROOT_STEPS; k++) tagr_ff[k] <= tagr_ff[k-1];
         rdiv_ff  <= rdiv_in;
         lo_ff    <= lo_in;
         q_ff     <= q_in;
         lend_ff[0] <= res_ff[ROOT_STEPS][LW-1:0];
         tagd_ff[0] <= tagr_ff[ROOT_STEPS];
         for (int j = 1; j <= QW; j++) begin
            lend_ff[j] <= lend_ff[j-1];
            tagd_ff[j] <= tagd_ff[j-1];
         end
         out_ff   <= out_in;
      end
   end

   assign vec_out = out_ff;

endmodule

>>> sv/look_at_view_matrix.sv
// Top level: fixed-point look-at view matrix pipeline.
// Usage:
//   req channel: one transaction carries eye, target and up hint (nine
//   signed Q16.16 words). rsp channel: one transaction per request with
//   the side, true-up and back rows and the three translation terms.
//   No configuration; FRACTION_BITS sets the fixed-point format.
// Throughput: one transaction per cycle while the output is not stalled.
// Two normalizer units dominate the path from req acceptance to rsp_tvalid:
//   each spends 32 stages on the square root and FRACTION_BITS+1 stages on
//   the per-lane divide, one bit per stage.
// Stall: the whole pipeline advances only when the output register is empty
//   or being taken, so req_tready follows rsp_tready while the output holds
//   a result; nothing is dropped or repeated.
// Reset: synchronous, active high; clears all valid bits, data is not reset.
// Degenerate inputs: eye equal to target, or an up hint parallel to the
//   view direction, give zero rows and zero translation where undefined.
`include "look_at_view_matrix_macros.svh"

module look_at_view_matrix #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // eye_x, eye_y, eye_z, target_x, target_y, target_z,
   // up_hint_x, up_hint_y, up_hint_z (32 bits each)
   input  logic [lvm_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // side_x/y/z, true_up_x/y/z, back_x/y/z (18 bits each),
   // shift_x/y/z (32 bits each), 6 zero pad bits
   output logic [lvm_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import lvm_pkg::*;

   localparam int FB       = FRACTION_BITS;
   localparam int UW       = FB + 2;          // unit component, holds +-1.0
   localparam int FW       = WORD_W + 1;      // target minus eye
   localparam int PW       = UW + WORD_W;     // unit times word product
   localparam int SW       = PW;              // raw side component
   localparam int DW       = PW + 1;          // three-term dot sum
   localparam int RP       = 2 * UW;          // unit times unit product
   localparam int NORM_LAT = FB + 41;
   localparam int TOTAL    = 2 * NORM_LAT + 9;
   localparam int S_IDX    = 2 * NORM_LAT + 2; // where side leaves its normalizer
   localparam logic signed [UW-1:0] ONE_S = UW'(1) << FB;
   localparam logic [DW-1:0] HALF = DW'(1) << (FB - 1);

   logic               ce;
   logic [TOTAL-1:0]   vld_ff, vld_in;

   logic signed [WORD_W-1:0] eye_w [3], tgt_w [3], up_w [3];

   // stage a
   logic signed [WORD_W-1:0] eye_a_ff [3], up_a_ff [3];
   logic signed [FW-1:0]     fwd_a_ff [3], fwd_a_in [3];
   // first normalizer and aligned operands
   logic signed [UW-1:0]     f_n [3];
   logic signed [WORD_W-1:0] eye_d1_ff [NORM_LAT][3], up_d1_ff [NORM_LAT][3];
   // stage b
   logic signed [PW-1:0]     xp_b_ff [6], xp_b_in [6], fe_b_ff [3], fe_b_in [3];
   logic signed [UW-1:0]     f_b_ff [3];
   logic signed [WORD_W-1:0] eye_b_ff [3];
   // stage c
   logic signed [SW-1:0]     sraw_c_ff [3], sraw_c_in [3];
   logic signed [DW-1:0]     fes_c_ff, fes_c_in;
   logic signed [UW-1:0]     f_c_ff [3];
   logic signed [WORD_W-1:0] eye_c_ff [3];
   // second normalizer and aligned operands
   logic signed [UW-1:0]     s_n [3];
   logic signed [UW-1:0]     f_d2_ff [NORM_LAT][3];
   logic signed [WORD_W-1:0] eye_d2_ff [NORM_LAT][3];
   logic signed [DW-1:0]     fes_d2_ff [NORM_LAT];
   // stage d
   logic signed [RP-1:0]     up_d_ff [6], up_d_in [6];
   logic signed [PW-1:0]     se_d_ff [3], se_d_in [3];
   logic signed [UW-1:0]     s_d_ff [3], f_d_ff [3];
   logic signed [WORD_W-1:0] eye_d_ff [3];
   logic signed [DW-1:0]     fes_d_ff;
   // stage e
   logic signed [RP-1:0]     uraw_e_ff [3], uraw_e_in [3];
   logic signed [DW-1:0]     ses_e_ff, ses_e_in;
   logic signed [UW-1:0]     s_e_ff [3], f_e_ff [3];
   logic signed [WORD_W-1:0] eye_e_ff [3];
   logic signed [DW-1:0]     fes_e_ff;
   // stage g
   logic signed [UW-1:0]     u_g_ff [3], u_g_in [3], s_g_ff [3], f_g_ff [3];
   logic signed [WORD_W-1:0] tx_g_ff, tx_g_in, tz_g_ff, tz_g_in, eye_g_ff [3];
   // stage h
   logic signed [PW-1:0]     ue_h_ff [3], ue_h_in [3];
   logic signed [UW-1:0]     u_h_ff [3], s_h_ff [3], f_h_ff [3];
   logic signed [WORD_W-1:0] tx_h_ff, tz_h_ff;
   // stage i
   logic signed [DW-1:0]     ues_i_ff, ues_i_in;
   logic signed [UW-1:0]     u_i_ff [3], s_i_ff [3], f_i_ff [3];
   logic signed [WORD_W-1:0] tx_i_ff, tz_i_ff;
   // output register
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   // round half away from zero, optional negate, saturate to a word
   function automatic logic signed [WORD_W-1:0] round_sat(
      input logic signed [DW-1:0] v,
      input logic                 negate
   );
      logic [DW-1:0] mag;
      logic [DW-1:0] r;
      logic          neg;
      mag = v[DW-1] ? (~unsigned'(v)) + DW'(1) : unsigned'(v);
      r   = (mag + HALF) >> FB;
      neg = v[DW-1] ^ negate;
      if (r == '0) begin
         return '0;
      end else if (!neg) begin
         if (r > DW'(32'h7FFF_FFFF)) return 32'sh7FFF_FFFF;
         return signed'(WORD_W'(r));
      end else begin
         if (r > DW'(33'h0_8000_0000)) return 32'sh8000_0000;
         return signed'(WORD_W'(~r + DW'(1)));
      end
   endfunction

   // round half away from zero and clamp to +-1.0
   function automatic logic signed [UW-1:0] round_unit(input logic signed [RP-1:0] v);
      logic [RP-1:0] mag;
      logic [RP-1:0] r;
      mag = v[RP-1] ? (~unsigned'(v)) + RP'(1) : unsigned'(v);
      r   = (mag + (RP'(1) << (FB - 1))) >> FB;
      if (r > RP'(ONE_S)) r = RP'(ONE_S);
      return v[RP-1] ? -signed'(UW'(r)) : signed'(UW'(r));
   endfunction

   assign ce         = !rsp_tvalid || rsp_tready;
   assign req_tready = ce;
   assign rsp_tvalid = vld_ff[TOTAL-1];
   assign rsp_tdata  = rsp_data_ff;
   assign vld_in     = {vld_ff[TOTAL-2:0], req_tvalid};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         eye_w[i] = signed'(req_tdata[i*WORD_W +: WORD_W]);
         tgt_w[i] = signed'(req_tdata[(i+3)*WORD_W +: WORD_W]);
         up_w[i]  = signed'(req_tdata[(i+6)*WORD_W +: WORD_W]);
         fwd_a_in[i] = FW'(tgt_w[i]) - FW'(eye_w[i]);
      end
   end

   lvm_norm3 #(.IN_W(FW), .FRACTION_BITS(FB)) u_norm_fwd (
      .clock  (clock),
      .ce     (ce),
      .vec_in (fwd_a_ff),
      .vec_out(f_n)
   );

   // side raw = f x up, plus forward dot eye; cross terms paired per component
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         xp_b_in[2*j]   = PW'(f_n[(j+1)%3]) * PW'(up_d1_ff[NORM_LAT-1][(j+2)%3]);
         xp_b_in[2*j+1] = PW'(f_n[(j+2)%3]) * PW'(up_d1_ff[NORM_LAT-1][(j+1)%3]);
         fe_b_in[j]     = PW'(f_n[j]) * PW'(eye_d1_ff[NORM_LAT-1][j]);
         sraw_c_in[j]   = xp_b_ff[2*j] - xp_b_ff[2*j+1];
      end
      fes_c_in = DW'(fe_b_ff[0]) + DW'(fe_b_ff[1]) + DW'(fe_b_ff[2]);
   end

   lvm_norm3 #(.IN_W(SW), .FRACTION_BITS(FB)) u_norm_side (
      .clock  (clock),
      .ce     (ce),
      .vec_in (sraw_c_ff),
      .vec_out(s_n)
   );

   // true up = s x f, plus side, forward and true-up dot eye terms
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         up_d_in[2*j]   = RP'(s_n[(j+1)%3]) * RP'(f_d2_ff[NORM_LAT-1][(j+2)%3]);
         up_d_in[2*j+1] = RP'(s_n[(j+2)%3]) * RP'(f_d2_ff[NORM_LAT-1][(j+1)%3]);
         se_d_in[j]     = PW'(s_n[j]) * PW'(eye_d2_ff[NORM_LAT-1][j]);
         uraw_e_in[j]   = up_d_ff[2*j] - up_d_ff[2*j+1];
         u_g_in[j]      = round_unit(uraw_e_ff[j]);
         ue_h_in[j]     = PW'(u_g_ff[j]) * PW'(eye_g_ff[j]);
      end
      ses_e_in = DW'(se_d_ff[0]) + DW'(se_d_ff[1]) + DW'(se_d_ff[2]);
      tx_g_in  = round_sat(ses_e_ff, 1'b1);
      tz_g_in  = round_sat(fes_e_ff, 1'b0);
      ues_i_in = DW'(ue_h_ff[0]) + DW'(ue_h_ff[1]) + DW'(ue_h_ff[2]);
   end

   // final pack: unit rows masked to the output field width
   always_comb begin
      logic signed [UW-1:0] nf;
      rsp_data_in = '0;
      for (int i = 0; i < 3; i++) begin
         nf = -f_i_ff[i];
         rsp_data_in[i*UNIT_OUT_W +: UNIT_OUT_W]     = UNIT_OUT_W'(s_i_ff[i]);
         rsp_data_in[(i+3)*UNIT_OUT_W +: UNIT_OUT_W] = UNIT_OUT_W'(u_i_ff[i]);
         rsp_data_in[(i+6)*UNIT_OUT_W +: UNIT_OUT_W] = UNIT_OUT_W'(nf);
      end
      rsp_data_in[9*UNIT_OUT_W +: WORD_W]            = tx_i_ff;
      rsp_data_in[9*UNIT_OUT_W + WORD_W +: WORD_W]   = round_sat(ues_i_ff, 1'b1);
      rsp_data_in[9*UNIT_OUT_W + 2*WORD_W +: WORD_W] = tz_i_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         eye_a_ff <= eye_w;
         up_a_ff  <= up_w;
         fwd_a_ff <= fwd_a_in;
         eye_d1_ff[0] <= eye_a_ff;
         up_d1_ff[0]  <= up_a_ff;
         for (int k = 1; k < NORM_LAT; k++) begin
            eye_d1_ff[k] <= eye_d1_ff[k-1];
            up_d1_ff[k]  <= up_d1_ff[k-1];
         end
         xp_b_ff  <= xp_b_in;
         fe_b_ff  <= fe_b_in;
         f_b_ff   <= f_n;
         eye_b_ff <= eye_d1_ff[NORM_LAT-1];
         sraw_c_ff <= sraw_c_in;
         fes_c_ff  <= fes_c_in;
         f_c_ff    <= f_b_ff;
         eye_c_ff  <= eye_b_ff;
         f_d2_ff[0]   <= f_c_ff;
         eye_d2_ff[0] <= eye_c_ff;
         fes_d2_ff[0] <= fes_c_ff;
         for (int k = 1; k < NORM_LAT; k++) begin
            f_d2_ff[k]   <= f_d2_ff[k-1];
            eye_d2_ff[k] <= eye_d2_ff[k-1];
            fes_d2_ff[k] <= fes_d2_ff[k-1];
         end
         up_d_ff  <= up_d_in;
         se_d_ff  <= se_d_in;
         s_d_ff   <= s_n;
         f_d_ff   <= f_d2_ff[NORM_LAT-1];
         eye_d_ff <= eye_d2_ff[NORM_LAT-1];
         fes_d_ff <= fes_d2_ff[NORM_LAT-1];
         uraw_e_ff <= uraw_e_in;
         ses_e_ff  <= ses_e_in;
         s_e_ff    <= s_d_ff;
         f_e_ff    <= f_d_ff;
         eye_e_ff  <= eye_d_ff;
         fes_e_ff  <= fes_d_ff;
         u_g_ff   <= u_g_in;
         tx_g_ff  <= tx_g_in;
         tz_g_ff  <= tz_g_in;
         s_g_ff   <= s_e_ff;
         f_g_ff   <= f_e_ff;
         eye_g_ff <= eye_e_ff;
         ue_h_ff  <= ue_h_in;
         u_h_ff   <= u_g_ff;
         s_h_ff   <= s_g_ff;
         f_h_ff   <= f_g_ff;
         tx_h_ff  <= tx_g_ff;
         tz_h_ff  <= tz_g_ff;
         ues_i_ff <= ues_i_in;
         u_i_ff   <= u_h_ff;
         s_i_ff   <= s_h_ff;
         f_i_ff   <= f_h_ff;
         tx_i_ff  <= tx_h_ff;
         tz_i_ff  <= tz_h_ff;
         rsp_data_ff <= rsp_data_in;
      end
   end

   // a held pipeline keeps every transaction in place
   `LVM_ASSERT_NXT(a_stall_freeze, !ce, $stable(vld_ff), "valid bits moved during stall")
   // the side normalizer never produces more than 1.0
   `LVM_ASSERT_IMP(a_side_unit, vld_ff[S_IDX], (s_n[0] <= ONE_S) && (s_n[0] >= -ONE_S) && (s_n[1] <= ONE_S) && (s_n[1] >= -ONE_S) && (s_n[2] <= ONE_S) && (s_n[2] >= -ONE_S), "side component beyond unit range")
   // zero forward must give zero side on the aligned transaction
   `LVM_ASSERT_IMP(a_zero_fwd_side, vld_ff[S_IDX] && (f_d2_ff[NORM_LAT-1][0] == '0) && (f_d2_ff[NORM_LAT-1][1] == '0) && (f_d2_ff[NORM_LAT-1][2] == '0), (s_n[0] == '0) && (s_n[1] == '0) && (s_n[2] == '0), "nonzero side with zero forward")

endmodule

>>> sim/tb_look_at_view_matrix.sv
// Testbench for the look-at view matrix pipeline: directed and random camera set-ups.
`timescale 1ns / 100ps

module tb_look_at_view_matrix;
   import lvm_pkg::*;

   localparam int FRAC       = 16;
   localparam int LATENCY    = 2 * (FRAC + 41) + 9;
   localparam int STALL_LIM  = 20000;
   localparam int RANDOM_CNT = 1930;

   typedef logic signed [31:0] word_type;
   typedef logic signed [17:0] unit_type;

   typedef struct {
      word_type eye[3];
      word_type target[3];
      word_type up_hint[3];
   } setup_type;

   typedef struct {
      unit_type side[3];
      unit_type true_up[3];
      unit_type back[3];
      word_type shift[3];
   } view_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   view_type views_pending[$];
   int    error_count;
   int    sent_count;
   int    got_count;
   int    idle_cycles;
   int    zero_fwd_count;
   int    sat_count;
   bit    rsp_idle_en;
   bit    rsp_holdoff;

   look_at_view_matrix #(.FRACTION_BITS(FRAC)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor: fixed-point look-at math at full precision
   // ---------------------------------------------------------------------

   function automatic logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] root;
      logic [63:0] bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n    = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // Scale magnitudes so the largest sits in [2^30, 2^31), then divide by
   // the truncated length with half-up rounding; zero vector stays zero.
   function automatic void unit_vector(input longint v[3], output longint n[3]);
      logic [63:0] m[3];
      logic [63:0] mx;
      logic [63:0] sum;
      logic [63:0] len;
      logic [63:0] q;
      mx = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = (v[i] < 0) ? -v[i] : v[i];
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
         for (int i = 0; i < 3; i++) n[i] = 0;
         return;
      end
      while (mx >= (64'd1 << 31)) begin
         mx = mx >> 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      end
      while (mx < (64'd1 << 30)) begin
         mx = mx << 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      end
      for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << FRAC) + (len >> 1)) / len;
         n[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
   endfunction

   function automatic void vec_cross(input longint a[3], input longint b[3],
                                     output longint p[3]);
      p[0] = a[1] * b[2] - a[2] * b[1];
      p[1] = a[2] * b[0] - a[0] * b[2];
      p[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   // Round half away from zero to the fraction width.
   function automatic longint round_fixed(longint v);
      logic [63:0] m;
      m = (v < 0) ? -v : v;
      m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic word_type clamp_word(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return word_type'(v);
   endfunction

   function automatic longint dot_eye(longint a[3], longint e[3]);
      return a[0] * e[0] + a[1] * e[1] + a[2] * e[2];
   endfunction

   function automatic view_type predict_view(setup_type s);
      longint eye[3], fwd[3], f[3], sraw[3], sd[3], uraw[3], u[3], up[3];
      longint one;
      longint r;
      view_type v;
      one = longint'(1) << FRAC;
      for (int i = 0; i < 3; i++) begin
         eye[i] = s.eye[i];
         up[i]  = s.up_hint[i];
         fwd[i] = longint'(s.target[i]) - longint'(s.eye[i]);
      end
      unit_vector(fwd, f);
      vec_cross(f, up, sraw);
      unit_vector(sraw, sd);
      vec_cross(sd, f, uraw);
      for (int i = 0; i < 3; i++) begin
         r = round_fixed(uraw[i]);
         if (r > one) r = one;
         if (r < -one) r = -one;
         u[i] = r;
         v.side[i]    = unit_type'(sd[i]);
         v.true_up[i] = unit_type'(u[i]);
         v.back[i]    = unit_type'(-f[i]);
      end
      v.shift[0] = clamp_word(-round_fixed(dot_eye(sd, eye)));
      v.shift[1] = clamp_word(-round_fixed(dot_eye(u, eye)));
      v.shift[2] = clamp_word(round_fixed(dot_eye(f, eye)));
      return v;
   endfunction

   // ---------------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------------

   // Sends one camera set-up; idles about 24% of cycles unless disabled.
   // Valid stays up on return so the next call can follow with no gap.
   task automatic send_setup(setup_type s, bit allow_idle = 1'b1);
      logic [REQ_DATA_W-1:0] packed_req;
      for (int i = 0; i < 3; i++) begin
         packed_req[32*i +: 32]       = s.eye[i];
         packed_req[32*(3+i) +: 32]   = s.target[i];
         packed_req[32*(6+i) +: 32]   = s.up_hint[i];
      end
      while (allow_idle && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      views_pending.push_back(predict_view(s));
      if (s.eye[0] == s.target[0] && s.eye[1] == s.target[1] && s.eye[2] == s.target[2])
         zero_fwd_count++;
      req_tvalid <= 1'b1;
      req_tdata  <= packed_req;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   function automatic word_type rand_word(int mode);
      case (mode)
         0: return word_type'($urandom);
         1: return word_type'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
         2: return word_type'($signed($urandom_range(0, 2000)) - 1000);
         default: begin
            case ($urandom_range(4))
               0: return 32'sh7fffffff;
               1: return 32'sh80000000;
               2: return 32'sh00010000;
               3: return -32'sh00010000;
               default: return 32'sh0;
            endcase
         end
      endcase
   endfunction

   function automatic setup_type rand_setup();
      setup_type s;
      int     mode;
      mode = $urandom_range(9);
      for (int i = 0; i < 3; i++) begin
         s.eye[i]     = rand_word(mode < 5 ? 1 : (mode < 8 ? 0 : $urandom_range(3)));
         s.target[i]  = rand_word(mode < 5 ? 1 : (mode < 8 ? 0 : $urandom_range(3)));
         s.up_hint[i] = rand_word(mode < 5 ? 1 : (mode < 8 ? 0 : $urandom_range(3)));
      end
      // Occasional degenerate set-ups: eye on target, or up along forward.
      case ($urandom_range(19))
         0: s.target = s.eye;
         1: for (int i = 0; i < 3; i++)
               s.up_hint[i] = word_type'((longint'(s.target[i]) - longint'(s.eye[i])) >>> 1);
         default: ;
      endcase
      return s;
   endfunction

   function automatic setup_type make_setup(word_type ex, word_type ey, word_type ez,
                                            word_type tx, word_type ty, word_type tz,
                                            word_type ux, word_type uy, word_type uz);
      setup_type s;
      s.eye     = '{ex, ey, ez};
      s.target  = '{tx, ty, tz};
      s.up_hint = '{ux, uy, uz};
      return s;
   endfunction

   // ---------------------------------------------------------------------
   // Response side: ready generation and checking
   // ---------------------------------------------------------------------

   initial begin
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_holdoff)
            rsp_tready <= 1'b0;
         else if (rsp_idle_en)
            rsp_tready <= ($urandom_range(99) >= 24);
         else
            rsp_tready <= 1'b1;
      end
   end

   task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
      if (expv !== actv) begin
         $error("%s mismatch: expected %0h, got %0h", name, expv, actv);
         error_count++;
      end
   endtask

   // Compares each accepted transaction with the oldest prediction.
   always @(posedge clock) begin
      view_type exp_v;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_count++;
         if (views_pending.size() == 0) begin
            $error("unexpected rsp transaction");
            error_count++;
         end else begin
            exp_v = views_pending.pop_front();
            for (int i = 0; i < 3; i++) begin
               check_field($sformatf("side[%0d]", i), 32'(exp_v.side[i]),
                           32'(unit_type'(rsp_tdata[18*i +: 18])));
               check_field($sformatf("true_up[%0d]", i), 32'(exp_v.true_up[i]),
                           32'(unit_type'(rsp_tdata[18*(3+i) +: 18])));
               check_field($sformatf("back[%0d]", i), 32'(exp_v.back[i]),
                           32'(unit_type'(rsp_tdata[18*(6+i) +: 18])));
               check_field($sformatf("shift[%0d]", i), exp_v.shift[i],
                           rsp_tdata[162 + 32*i +: 32]);
               if (exp_v.shift[i] == 32'sh7fffffff || exp_v.shift[i] == 32'sh80000000)
                  sat_count++;
            end
         end
      end
   end

   // Watchdog: stop if no transaction moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIM) begin
         $display("watchdog: no progress for %0d cycles", STALL_LIM);
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Field extremes, axis-aligned cameras and the degenerate set-ups.
   task automatic test_directed();
      word_type one;
      word_type mx;
      word_type mn;
      one = 32'sh00010000;
      mx  = 32'sh7fffffff;
      mn  = 32'sh80000000;
      send_setup(make_setup(0, 0, one, 0, 0, 0, 0, one, 0));
      send_setup(make_setup(0, 0, 0, 0, 0, -one, 0, one, 0));
      send_setup(make_setup(one, 2*one, 3*one, -one, 0, 0, 0, 0, one));
      // eye on target
      send_setup(make_setup(one, one, one, one, one, one, 0, one, 0));
      send_setup(make_setup(0, 0, 0, 0, 0, 0, 0, 0, 0));
      // up hint parallel to forward, and zero up hint
      send_setup(make_setup(0, 0, 0, 0, 0, one, 0, 0, 5*one));
      send_setup(make_setup(0, 0, 0, one, 0, 0, 0, 0, 0));
      // extremes: saturating translation and huge vectors
      send_setup(make_setup(mx, mx, mx, mn, mn, mn, mx, mn, mx));
      send_setup(make_setup(mn, mn, mn, mx, mx, mx, mn, mx, mn));
      send_setup(make_setup(mx, mn, mx, 0, 0, 0, mn, mn, mn));
      send_setup(make_setup(mn, mx, 0, mx, mn, 0, 0, 0, mx));
      send_setup(make_setup(-1, -1, -1, 0, 0, 0, 1, 0, 0));
      send_setup(make_setup(1, 0, 0, 0, 1, 0, 0, 0, 1));
      send_setup(make_setup(32'shffffffff, 32'sh55555555, 32'shaaaaaaaa,
                            32'sh55555555, 32'shaaaaaaaa, 32'shffffffff,
                            32'shaaaaaaaa, 32'shffffffff, 32'sh55555555));
      send_setup(make_setup(mx, 0, 0, mx, 0, one, mn, mn, 0));
   endtask

   // Random traffic with idling on both sides.
   task automatic test_random(int count);
      for (int n = 0; n < count; n++) send_setup(rand_setup());
   endtask

   // Back-to-back with no idling at all.
   task automatic test_streaming(int count);
      rsp_idle_en = 1'b0;
      for (int n = 0; n < count; n++) send_setup(rand_setup(), 1'b0);
      rsp_idle_en = 1'b1;
   endtask

   // Receiver holds off long enough for the pipeline to fill and push back.
   task automatic test_backpressure();
      rsp_holdoff = 1'b1;
      fork
         begin
            repeat (LATENCY * 3) @(posedge clock);
            rsp_holdoff = 1'b0;
         end
         for (int n = 0; n < LATENCY + 40; n++) send_setup(rand_setup(), 1'b0);
      join
   endtask

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      error_count = 0;
      sent_count  = 0;
      got_count   = 0;
      zero_fwd_count = 0;
      sat_count   = 0;
      rsp_idle_en = 1'b1;
      rsp_holdoff = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(RANDOM_CNT / 2);
      test_backpressure();
      test_streaming(300);
      test_random(RANDOM_CNT / 2 - 300 - LATENCY);
      req_tvalid <= 1'b0;

      while (views_pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      $display("covered %0d camera set-ups (%0d with eye on target), %0d results",
               sent_count, zero_fwd_count, got_count);
      $display("saturated translation terms seen: %0d; long output stall exercised",
               sat_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
